// ===== hw/rtl/mpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfd_pkg: shared definitions for the page-addressed framebuffer draw block
// Display geometry, store sizing and command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpfd_pkg;

  // Display geometry; the store keeps one byte per column per page of 8 rows
  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W         = $clog2(STORE_BYTES);

  // Clip limits at the width of a coordinate plus span
  localparam logic [8:0] WIDTH_LIM  = 9'(DISPLAY_WIDTH);
  localparam logic [8:0] HEIGHT_LIM = 9'(DISPLAY_HEIGHT);

  // Address step from one page to the next, and the last store address
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(DISPLAY_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  // Byte constants
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [2:0] BIT_TOP    = 3'h7;

  // Command codes
  localparam logic [2:0] CMD_PIXEL = 3'd0;
  localparam logic [2:0] CMD_HLINE = 3'd1;
  localparam logic [2:0] CMD_VLINE = 3'd2;
  localparam logic [2:0] CMD_RECT  = 3'd3;
  localparam logic [2:0] CMD_FILL  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLEAR  = 8'b0000_0010,
    S_FILL   = 8'b0000_0100,
    S_SETUP  = 8'b0000_1000,
    S_RD     = 8'b0001_0000,
    S_WR     = 8'b0010_0000,
    S_RDBYTE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mpfd_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mpfd_cmd_if: command channel
// Valid/ready channel carrying one drawing or read command per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpfd_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [7:0] span_width;
  logic [7:0] span_height;
  logic       set_pixel;
  logic [9:0] read_index;

  modport source (
    output valid, cmd, x_pos, y_pos, span_width, span_height, set_pixel, read_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, x_pos, y_pos, span_width, span_height, set_pixel, read_index,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mpfd_res_if.sv =====
// ----------------------------------------------------------------------------
// mpfd_res_if: result channel
// Valid/ready channel carrying one result word per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_valid;

  modport source (
    output valid, read_byte, read_valid,
    input  ready
  );

  modport sink (
    input  valid, read_byte, read_valid,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mpfd_ram.sv =====
// ----------------------------------------------------------------------------
// mpfd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mono_page_framebuffer_draw.sv =====
// Sequencing: pixel, line and rectangle commands pass through a setup state, then one
//   read-modify-write per framebuffer byte touched after clipping, then the done state.
// Fill-all writes every store byte in turn; read byte reads one addressed byte.
// Throughput: one command at a time; the RAM port pair and the byte merge unit set the pace.
// Reset: synchronous; after reset a clearing pass over all STORE_BYTES addresses zeroes
//   the store while the command channel is held not ready.
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw: monochrome page-addressed framebuffer
// Executes pixel, line, rectangle, fill and read commands on a byte store
// where each byte holds eight vertical pixels of one column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mono_page_framebuffer_draw (
  input wire logic  clk,
  input wire logic  rst,
  mpfd_cmd_if.sink  cmd_ch,
  mpfd_res_if.source res_ch
);

  import mpfd_pkg::*;

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t state;
  state_t state_next;

  // Command latched at accept. Width is forced to one for pixel and vertical line commands,
  // height for pixel and horizontal line commands, so every draw is a clipped rectangle.
  logic [7:0] xs;
  logic [7:0] ys;
  logic [7:0] ws;
  logic [7:0] hs;
  logic       set_on;
  logic       rd_ok;

  // Walk state: current column and page, byte address, and the address of
  // the first column of the current page.
  logic [7:0]        col;
  logic [7:0]        x_last;
  logic [7:0]        y_last;
  logic [4:0]        page;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] row_base;
  logic [7:0]        fill_byte;

  // Result waiting to move into the output register
  logic [7:0] res_byte;
  logic       res_valid;

  // Output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_rvalid;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  logic accept;
  logic out_free;

  assign cmd_ch.ready     = (state == S_IDLE);
  assign accept           = cmd_ch.valid && cmd_ch.ready;
  assign out_free         = !out_valid || res_ch.ready;

  assign res_ch.valid      = out_valid;
  assign res_ch.read_byte  = out_byte;
  assign res_ch.read_valid = out_rvalid;

  // --------------------------------------------------------------------------
  // Clip computation for the setup cycle
  // --------------------------------------------------------------------------
  logic [8:0] sum_x;
  logic [8:0] sum_y;
  logic [8:0] xe;
  logic [8:0] ye;
  logic       empty;

  always_comb begin
    sum_x = {1'b0, xs} + {1'b0, ws};
    sum_y = {1'b0, ys} + {1'b0, hs};
    xe    = (sum_x > WIDTH_LIM)  ? WIDTH_LIM  : sum_x;
    ye    = (sum_y > HEIGHT_LIM) ? HEIGHT_LIM : sum_y;
    empty = ({1'b0, xs} >= xe) || ({1'b0, ys} >= ye);
  end

  // --------------------------------------------------------------------------
  // Byte merge unit: row mask for the current page, then set or clear bits
  // --------------------------------------------------------------------------
  logic [2:0] bit_lo;
  logic [2:0] bit_hi;
  logic [7:0] mask;
  logic [7:0] merged;
  logic       col_end;
  logic       page_end;

  always_comb begin
    // First page starts at the top row of the span, last page ends at its bottom row
    bit_lo   = (page == ys[7:3])     ? ys[2:0]     : 3'h0;
    bit_hi   = (page == y_last[7:3]) ? y_last[2:0] : BIT_TOP;
    mask     = (BYTE_ONES << bit_lo) & (BYTE_ONES >> (BIT_TOP - bit_hi));
    merged   = set_on ? (ram_rdata | mask) : (ram_rdata & ~mask);
    col_end  = (col == x_last);
    page_end = (page == y_last[7:3]);
  end

  // --------------------------------------------------------------------------
  // RAM port control
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = merged;
    ram_raddr = addr;
    unique case (state)
      S_IDLE: begin
        // Address the read command's byte straight from the channel
        ram_raddr = ADDR_W'(cmd_ch.read_index);
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = BYTE_ZERO;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_byte;
      end
      S_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mpfd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_ch.cmd) inside
            CMD_PIXEL, CMD_HLINE, CMD_VLINE, CMD_RECT: state_next = S_SETUP;
            CMD_FILL:                                   state_next = S_FILL;
            CMD_READ:                                   state_next = S_RDBYTE;
            default:                                    state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (addr == LAST_ADDR) state_next = S_IDLE;
      end
      S_FILL: begin
        if (addr == LAST_ADDR) state_next = S_DONE;
      end
      S_SETUP: begin
        state_next = empty ? S_DONE : S_RD;
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        state_next = (col_end && page_end) ? S_DONE : S_RD;
      end
      S_RDBYTE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      // Start the clearing pass at address zero
      state     <= S_CLEAR;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // Address walk
      unique case (state) inside
        S_IDLE: begin
          if (accept) addr <= '0;
        end
        S_CLEAR, S_FILL: begin
          addr <= addr + ADDR_W'(1);
        end
        S_SETUP: begin
          addr <= ADDR_W'(xs) + ADDR_W'(ys[7:3]) * ROW_STEP;
        end
        S_WR: begin
          // Advance along the row; at its end drop to the next page
          if (col_end) begin
            addr <= row_base + ROW_STEP;
          end else begin
            addr <= addr + ADDR_W'(1);
          end
        end
        default: begin
          addr <= addr;
        end
      endcase

      // Output register: load a finished result once the slot is free
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      xs        <= cmd_ch.x_pos;
      ys        <= cmd_ch.y_pos;
      set_on    <= cmd_ch.set_pixel;
      ws        <= (cmd_ch.cmd == CMD_PIXEL || cmd_ch.cmd == CMD_VLINE) ? 8'd1
                                                                        : cmd_ch.span_width;
      hs        <= (cmd_ch.cmd == CMD_PIXEL || cmd_ch.cmd == CMD_HLINE) ? 8'd1
                                                                        : cmd_ch.span_height;
      rd_ok     <= (32'(cmd_ch.read_index) < STORE_BYTES);
      fill_byte <= cmd_ch.set_pixel ? BYTE_ONES : BYTE_ZERO;
      res_byte  <= BYTE_ZERO;
      res_valid <= 1'b0;
    end

    unique case (state)
      S_SETUP: begin
        col      <= xs;
        page     <= ys[7:3];
        x_last   <= 8'(xe - 9'd1);
        y_last   <= 8'(ye - 9'd1);
        row_base <= ADDR_W'(xs) + ADDR_W'(ys[7:3]) * ROW_STEP;
      end
      S_WR: begin
        if (col_end) begin
          col      <= xs;
          page     <= page + 5'd1;
          row_base <= row_base + ROW_STEP;
        end else begin
          col <= col + 8'd1;
        end
      end
      S_RDBYTE: begin
        // Bytes past the store read as zero
        res_byte  <= rd_ok ? ram_rdata : BYTE_ZERO;
        res_valid <= 1'b1;
      end
      default: begin
        col <= col;
      end
    endcase

    if (state == S_DONE && out_free) begin
      out_byte   <= res_byte;
      out_rvalid <= res_valid;
    end
  end

`ifndef SYNTHESIS
  // A merge write lands inside the store after clipping
  a_wr_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (32'(addr) < STORE_BYTES))
    else $error("draw write outside the store");

  // Every byte touched by a draw has at least one pixel of the span
  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (mask != BYTE_ZERO))
    else $error("draw write with empty row mask");

  // The column walk stays within the clipped span
  a_col_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (col >= xs && col <= x_last))
    else $error("column outside the clipped span");

  // A read command produces a result marked as read data
  a_read_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDBYTE) |=> (state == S_DONE && res_valid))
    else $error("read command result not marked valid");

  // A result loads into the output register only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word without a finished command");
`endif

endmodule

`default_nettype wire

// ===== sim/mono_page_framebuffer_draw_tb.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_tb: self-checking bench for the framebuffer block
// Drives pixel, line, rectangle, fill, read and spare command words with
// random idle gaps on both channels. An in-bench copy of the store predicts
// every result word, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_page_framebuffer_draw_tb;
  import mpfd_pkg::*;

  // Codes 6 and 7 are not commands; the block must answer them with an empty word
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_WORDS = 1000;
  // Slowest command is a full-screen rectangle, a read-modify-write of every store byte;
  // the clearing pass after reset and a result stall both add to the longest quiet stretch.
  localparam int QUIET_LIMIT  = 12000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] span_width;
    logic [7:0] span_height;
    logic       set_pixel;
    logic [9:0] read_index;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpfd_cmd_if cmd_ch ();
  mpfd_res_if res_ch ();

  mono_page_framebuffer_draw dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the page-addressed store, updated as each command is accepted
  logic [7:0]  frame_model [STORE_BYTES];
  cmd_word_t   cmd_backlog [$];
  res_word_t   read_expect_q [$];

  int mismatches   = 0;
  int cmd_taken    = 0;   // words accepted by the block (monitor side)
  int cmd_offered  = 0;   // words put on the bus (driver side)
  int cmd_gap      = 0;
  int cmd_calm     = 0;
  int res_stall    = 0;
  int res_calm     = 0;
  int quiet_cycles = 0;
  int cycle_count  = 0;
  int n_draws      = 0;
  int n_fills      = 0;
  int n_reads      = 0;
  int n_spare      = 0;

  // Last drawing position, so that reads mostly land where something changed
  int aim_x = 0;
  int aim_y = 0;

  task automatic report_mismatch(input string what, input int want, input int got);
    if (mismatches < 100)
      $display("[%0t] mismatch: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  // Set or clear every visible pixel of a clipped span; coordinates never wrap
  function automatic void paint_span(input int x, input int y, input int w, input int h,
                                     input logic on);
    int col_end, row_end, col, row;
    col_end = x + w;
    row_end = y + h;
    if (col_end > DISPLAY_WIDTH) col_end = DISPLAY_WIDTH;
    if (row_end > DISPLAY_HEIGHT) row_end = DISPLAY_HEIGHT;
    for (col = x; col < col_end; col++)
      for (row = y; row < row_end; row++)
        frame_model[col + (row / 8) * DISPLAY_WIDTH][row % 8] = on;
  endfunction

  // Apply one accepted command to the shadow store and return the word it answers with
  function automatic res_word_t apply_command(input cmd_word_t c);
    res_word_t r;
    int idx;
    r = '0;
    case (c.cmd)
      CMD_PIXEL: paint_span(c.x_pos, c.y_pos, 1, 1, c.set_pixel);
      CMD_HLINE: paint_span(c.x_pos, c.y_pos, c.span_width, 1, c.set_pixel);
      CMD_VLINE: paint_span(c.x_pos, c.y_pos, 1, c.span_height, c.set_pixel);
      CMD_RECT:  paint_span(c.x_pos, c.y_pos, c.span_width, c.span_height, c.set_pixel);
      CMD_FILL: begin
        for (idx = 0; idx < STORE_BYTES; idx++)
          frame_model[idx] = c.set_pixel ? BYTE_ONES : BYTE_ZERO;
      end
      CMD_READ: begin
        r.read_valid = 1'b1;
        if (c.read_index < STORE_BYTES) r.read_byte = frame_model[c.read_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_word_t directed(input logic [2:0] cmd, input int x, input int y,
                                         input int w, input int h, input logic on,
                                         input int idx);
    cmd_word_t c;
    c.cmd         = cmd;
    c.x_pos       = 8'(x);
    c.y_pos       = 8'(y);
    c.span_width  = 8'(w);
    c.span_height = 8'(h);
    c.set_pixel   = on;
    c.read_index  = 10'(idx);
    return c;
  endfunction

  // Mostly short gaps, some medium, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // Random command: all fields random first so unused ones toggle, then shaped
  // per command. Most draws stay on screen with small spans; a few go wide.
  function automatic cmd_word_t random_command();
    cmd_word_t c;
    int pick, col, row;
    c.cmd         = 3'($urandom_range(0, 7));
    c.x_pos       = 8'($urandom_range(0, 255));
    c.y_pos       = 8'($urandom_range(0, 255));
    c.span_width  = 8'($urandom_range(0, 255));
    c.span_height = 8'($urandom_range(0, 255));
    c.set_pixel   = 1'($urandom_range(0, 1));
    c.read_index  = 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 20)      c.cmd = CMD_PIXEL;
    else if (pick < 32) c.cmd = CMD_HLINE;
    else if (pick < 44) c.cmd = CMD_VLINE;
    else if (pick < 54) c.cmd = CMD_RECT;
    else if (pick < 55) c.cmd = CMD_FILL;
    else if (pick < 93) c.cmd = CMD_READ;
    else                c.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;

    if (c.cmd inside {CMD_PIXEL, CMD_HLINE, CMD_VLINE, CMD_RECT}) begin
      if ($urandom_range(0, 6) != 0) begin
        c.x_pos = 8'($urandom_range(0, DISPLAY_WIDTH - 1));
        c.y_pos = 8'($urandom_range(0, DISPLAY_HEIGHT - 1));
      end
      aim_x = c.x_pos;
      aim_y = c.y_pos;
    end
    if (c.cmd == CMD_HLINE && $urandom_range(0, 4) != 0)
      c.span_width = 8'($urandom_range(0, 20));
    if (c.cmd == CMD_VLINE && $urandom_range(0, 4) != 0)
      c.span_height = 8'($urandom_range(0, 24));
    // Full-size rectangles are slow, touching every store byte; keep them rare
    if (c.cmd == CMD_RECT && $urandom_range(0, 32) != 0) begin
      c.span_width  = 8'($urandom_range(0, 12));
      c.span_height = 8'($urandom_range(0, 16));
    end
    if (c.cmd == CMD_READ && $urandom_range(0, 9) < 7) begin
      col = aim_x + int'($urandom_range(0, 4)) - 2;
      row = aim_y + int'($urandom_range(0, 16)) - 8;
      if (col >= 0 && col < DISPLAY_WIDTH && row >= 0 && row < DISPLAY_HEIGHT)
        c.read_index = 10'(col + (row / 8) * DISPLAY_WIDTH);
    end
    return c;
  endfunction

  // Command driver: present the next backlog word at the falling edge, hold it
  // until the monitor has seen it taken, then idle for a random gap.
  always @(negedge clk) begin : cmd_driver
    cmd_word_t w;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && cmd_taken != cmd_offered) begin
      // hold the word until it is accepted
    end else if (cmd_gap > 0) begin
      cmd_gap--;
      cmd_ch.valid <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      w = cmd_backlog.pop_front();
      cmd_ch.cmd         <= w.cmd;
      cmd_ch.x_pos       <= w.x_pos;
      cmd_ch.y_pos       <= w.y_pos;
      cmd_ch.span_width  <= w.span_width;
      cmd_ch.span_height <= w.span_height;
      cmd_ch.set_pixel   <= w.set_pixel;
      cmd_ch.read_index  <= w.read_index;
      cmd_ch.valid       <= 1'b1;
      cmd_offered++;
      // Stretches with no gaps at all, otherwise a random gap after each word
      if (cmd_calm > 0) begin
        cmd_calm--;
        cmd_gap = 0;
      end else begin
        cmd_gap = idle_len();
        if ($urandom_range(0, 49) == 0) cmd_calm = $urandom_range(20, 80);
      end
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // Result sink: drop ready at random, independent of whether a word is waiting,
  // so that stalls hit every phase of the block's sequencing.
  always @(negedge clk) begin : res_sink
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_stall--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (res_calm > 0) begin
        res_calm--;
      end else begin
        if ($urandom_range(0, 2) == 0) res_stall = idle_len();
        if ($urandom_range(0, 199) == 0) res_calm = $urandom_range(50, 300);
      end
    end
  end

  // Monitor: check the result word first so that a stray result is never paired
  // with the prediction of a command accepted on the same edge.
  always @(posedge clk) begin : monitor
    res_word_t want;
    cmd_word_t seen;
    if (!rst) begin
      cycle_count++;
      if (res_ch.valid && res_ch.ready) begin
        if (read_expect_q.size() == 0) begin
          report_mismatch("result word with no command pending", 0,
                          {res_ch.read_valid, res_ch.read_byte});
        end else begin
          want = read_expect_q.pop_front();
          if (res_ch.read_byte !== want.read_byte)
            report_mismatch("read_byte", want.read_byte, res_ch.read_byte);
          if (res_ch.read_valid !== want.read_valid)
            report_mismatch("read_valid", want.read_valid, res_ch.read_valid);
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen = '{cmd: cmd_ch.cmd, x_pos: cmd_ch.x_pos, y_pos: cmd_ch.y_pos,
                 span_width: cmd_ch.span_width, span_height: cmd_ch.span_height,
                 set_pixel: cmd_ch.set_pixel, read_index: cmd_ch.read_index};
        read_expect_q.push_back(apply_command(seen));
        cmd_taken++;
        case (seen.cmd)
          CMD_FILL: n_fills++;
          CMD_READ: n_reads++;
          CMD_SPARE_LO, CMD_SPARE_HI: n_spare++;
          default: n_draws++;
        endcase
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long
  always @(posedge clk) begin : watchdog
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no word moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, read_expect_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    // Known values on every input from time zero
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CMD_PIXEL;
    cmd_ch.x_pos       = '0;
    cmd_ch.y_pos       = '0;
    cmd_ch.span_width  = '0;
    cmd_ch.span_height = '0;
    cmd_ch.set_pixel   = 1'b0;
    cmd_ch.read_index  = '0;
    res_ch.ready       = 1'b0;
    for (i = 0; i < STORE_BYTES; i++) frame_model[i] = BYTE_ZERO;

    // Directed part: corners, clipping on both axes, zero spans, lines and
    // rectangles running past the edge, fill both ways, and spare codes.
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 0));
    cmd_backlog.push_back(directed(CMD_PIXEL, 0,   0,   0,   0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_PIXEL, 127, 63,  0,   0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_PIXEL, 128, 5,   0,   0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_PIXEL, 5,   64,  0,   0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_PIXEL, 255, 255, 255, 255, 1'b1, 1023));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 0));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 1023));
    cmd_backlog.push_back(directed(CMD_HLINE, 120, 9,   255, 0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_HLINE, 3,   3,   0,   7,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_VLINE, 10,  0,   0,   255, 1'b1, 0));
    cmd_backlog.push_back(directed(CMD_VLINE, 20,  20,  9,   0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 248));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 906));
    cmd_backlog.push_back(directed(CMD_RECT,  60,  5,   10,  20,  1'b1, 0));
    cmd_backlog.push_back(directed(CMD_RECT,  30,  30,  0,   20,  1'b1, 0));
    cmd_backlog.push_back(directed(CMD_RECT,  30,  30,  20,  0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 192));
    cmd_backlog.push_back(directed(CMD_PIXEL, 60,  5,   0,   0,   1'b0, 0));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 60));
    cmd_backlog.push_back(directed(CMD_FILL,  0,   0,   0,   0,   1'b1, 0));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 517));
    cmd_backlog.push_back(directed(CMD_RECT,  0,   0,   255, 255, 1'b0, 0));
    cmd_backlog.push_back(directed(CMD_READ,  0,   0,   0,   0,   1'b0, 1023));
    cmd_backlog.push_back(directed(CMD_SPARE_LO, 17, 9, 3,   3,   1'b1, 77));
    cmd_backlog.push_back(directed(CMD_SPARE_HI, 255, 255, 255, 255, 1'b1, 1023));
    cmd_backlog.push_back(directed(CMD_FILL,  255, 255, 255, 255, 1'b0, 1023));

    // Random part; spare codes change nothing, so they do not count
    i = 0;
    while (i < RANDOM_WORDS) begin
      cmd_backlog.push_back(random_command());
      if (cmd_backlog[$].cmd != CMD_SPARE_LO && cmd_backlog[$].cmd != CMD_SPARE_HI) i++;
    end

    // Hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every word sent and every predicted result received
    @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || read_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands in %0d cycles: %0d draws, %0d fills, %0d reads, %0d spare",
             cmd_taken, cycle_count, n_draws, n_fills, n_reads, n_spare);
    $display("mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
